/* src/mks_pkg.sv */
// Package for the matrix keypad scanner: configuration widths, register
// indexes, the result beat type and the 4x4 key map. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mks_pkg;

  localparam int ROW_COUNT_DEF    = 4;
  localparam int COLUMN_COUNT_DEF = 4;
  localparam int TIMER_BITS_DEF   = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int EDGE_W    = 4;
  localparam int MAP_DIM   = 4;

  localparam logic [CFG_W-1:0] COLUMN_DWELL_RST  = 16'd25;
  localparam logic [CFG_W-1:0] LOCKOUT_TICKS_RST = 16'd325;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMN_DWELL  = 1'b0,
    REG_LOCKOUT_TICKS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0] column_drive;
    logic       key_valid;
    logic [7:0] key_code;
    logic [1:0] key_row;
    logic [1:0] key_column;
  } result_t;

  localparam logic [7:0] KEYMAP [MAP_DIM*MAP_DIM] = '{
    8'h31, 8'h32, 8'h33, 8'h41,
    8'h34, 8'h35, 8'h36, 8'h42,
    8'h37, 8'h38, 8'h39, 8'h43,
    8'h2A, 8'h30, 8'h23, 8'h44
  };

  function automatic logic [7:0] key_char(input logic [1:0] row, input logic [1:0] col);
    return KEYMAP[{row, col}];
  endfunction

endpackage

`default_nettype wire

/* src/mks_in_if.sv */
// Input channel of the keypad scanner: valid/ready plus one tick of row edges.
// Depends on mks_pkg for the edge width.
`timescale 1ns / 1ps
`default_nettype none

interface mks_in_if;
  logic                       valid;
  logic                       ready;
  logic [mks_pkg::EDGE_W-1:0] row_edges;

  modport source (output valid, output row_edges, input ready);
  modport sink   (input valid, input row_edges, output ready);
endinterface

`default_nettype wire

/* src/mks_out_if.sv */
// Result channel of the keypad scanner: valid/ready plus column drive and key report.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mks_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] column_drive;
  logic       key_valid;
  logic [7:0] key_code;
  logic [1:0] key_row;
  logic [1:0] key_column;

  modport source (output valid, output column_drive, output key_valid, output key_code,
                  output key_row, output key_column, input ready);
  modport sink   (input valid, input column_drive, input key_valid, input key_code,
                  input key_row, input key_column, output ready);
endinterface

`default_nettype wire

/* src/matrix_keypad_scanner_core.sv */
// Top level of the matrix keypad scanner: config registers, scan state, output register.
// Depends on mks_pkg, mks_in_if, mks_out_if and mks_step.
// An accepted tick's result beat is registered in the output register and shows in the cycle after it is taken.
// Throughput: one tick per cycle; in_ch.ready drops only while a result beat is held
// by a stalled out_ch.ready.
// Reset (synchronous, rst_n low): no column driven, dwell and lockout counters zero,
// column_dwell 25, lockout_ticks 325, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module matrix_keypad_scanner_core #(
  parameter int ROW_COUNT    = mks_pkg::ROW_COUNT_DEF,
  parameter int COLUMN_COUNT = mks_pkg::COLUMN_COUNT_DEF,
  parameter int TIMER_BITS   = mks_pkg::TIMER_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mks_in_if.sink                             in_ch,
  mks_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [mks_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mks_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int LOCK_ROWS = (ROW_COUNT < mks_pkg::EDGE_W) ? ROW_COUNT : mks_pkg::EDGE_W;
  localparam int SCAN_W    = $clog2(COLUMN_COUNT + 1);
  localparam logic [SCAN_W-1:0] SCAN_NONE = SCAN_W'(COLUMN_COUNT);

  logic [mks_pkg::CFG_W-1:0] column_dwell_r;
  logic [mks_pkg::CFG_W-1:0] lockout_ticks_r;
  logic [SCAN_W-1:0]         scan_col_r;
  logic [SCAN_W-1:0]         scan_col_nxt;
  logic [TIMER_BITS-1:0]     dwell_r;
  logic [TIMER_BITS-1:0]     dwell_nxt;
  logic [TIMER_BITS-1:0]     lockout_r   [LOCK_ROWS];
  logic [TIMER_BITS-1:0]     lockout_nxt [LOCK_ROWS];
  mks_pkg::result_t          result_nxt;
  mks_pkg::result_t          result_r;
  logic                      out_valid_r;
  logic                      in_fire;

  logic [TIMER_BITS+mks_pkg::CFG_W-1:0] dwell_ext;
  logic [TIMER_BITS+mks_pkg::CFG_W-1:0] debounce_ext;

  assign dwell_ext    = {{TIMER_BITS{1'b0}}, column_dwell_r};
  assign debounce_ext = {{TIMER_BITS{1'b0}}, lockout_ticks_r};

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_dwell_r  <= mks_pkg::COLUMN_DWELL_RST;
      lockout_ticks_r <= mks_pkg::LOCKOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (mks_pkg::cfg_reg_t'(cfg_index))
        mks_pkg::REG_COLUMN_DWELL:  column_dwell_r  <= cfg_wdata;
        mks_pkg::REG_LOCKOUT_TICKS: lockout_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mks_step #(
    .LOCK_ROWS    (LOCK_ROWS),
    .COLUMN_COUNT (COLUMN_COUNT),
    .TIMER_BITS   (TIMER_BITS),
    .SCAN_W       (SCAN_W)
  ) u_step (
    .scan_col     (scan_col_r),
    .dwell        (dwell_r),
    .lockout      (lockout_r),
    .row_edges    (in_ch.row_edges),
    .dwell_lim    (dwell_ext[TIMER_BITS-1:0]),
    .debounce_lim (debounce_ext[TIMER_BITS-1:0]),
    .scan_col_nxt (scan_col_nxt),
    .dwell_nxt    (dwell_nxt),
    .lockout_nxt  (lockout_nxt),
    .result       (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_col_r <= SCAN_NONE;
      dwell_r    <= '0;
      for (int r = 0; r < LOCK_ROWS; r++) begin
        lockout_r[r] <= '0;
      end
    end else if (in_fire) begin
      scan_col_r <= scan_col_nxt;
      dwell_r    <= dwell_nxt;
      for (int r = 0; r < LOCK_ROWS; r++) begin
        lockout_r[r] <= lockout_nxt[r];
      end
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.column_drive = result_r.column_drive;
  assign out_ch.key_valid    = result_r.key_valid;
  assign out_ch.key_code     = result_r.key_code;
  assign out_ch.key_row      = result_r.key_row;
  assign out_ch.key_column   = result_r.key_column;

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_col_r <= SCAN_NONE)
    else $error("scan column beyond range");

  a_report_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.key_valid |->
      (result_r.column_drive == 4'b0000 || result_r.column_drive == 4'b0001))
    else $error("key report did not restart the scan");

  a_drive_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(result_r.column_drive))
    else $error("more than one column driven");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result beat stalled");

endmodule

`default_nettype wire

/* src/mks_step.sv */
// One tick of the scanner: lockout countdown, edge accept, key report, column advance.
// Pure combinational; depends on mks_pkg for the result type and key map.
`timescale 1ns / 1ps
`default_nettype none

module mks_step #(
  parameter int LOCK_ROWS    = 4,
  parameter int COLUMN_COUNT = 4,
  parameter int TIMER_BITS   = 16,
  parameter int SCAN_W       = 3
) (
  input  wire logic [SCAN_W-1:0]          scan_col,
  input  wire logic [TIMER_BITS-1:0]      dwell,
  input  wire logic [TIMER_BITS-1:0]      lockout [LOCK_ROWS],
  input  wire logic [mks_pkg::EDGE_W-1:0] row_edges,
  input  wire logic [TIMER_BITS-1:0]      dwell_lim,
  input  wire logic [TIMER_BITS-1:0]      debounce_lim,
  output      logic [SCAN_W-1:0]          scan_col_nxt,
  output      logic [TIMER_BITS-1:0]      dwell_nxt,
  output      logic [TIMER_BITS-1:0]      lockout_nxt [LOCK_ROWS],
  output      mks_pkg::result_t           result
);

  localparam logic [SCAN_W-1:0]     SCAN_NONE = SCAN_W'(COLUMN_COUNT);
  localparam logic [SCAN_W-1:0]     SCAN_LAST = SCAN_W'(COLUMN_COUNT - 1);
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic                    driven;
  logic [LOCK_ROWS-1:0]    accept;
  logic                    found;
  logic [1:0]              hit_row;
  logic [SCAN_W+3:0]       hit_ext;
  logic [3:0]              hit_col;
  logic [SCAN_W-1:0]       scan_mid;
  logic [TIMER_BITS-1:0]   dwell_inc;
  logic [SCAN_W+3:0]       new_ext;
  logic [3:0]              new_col;

  always_comb begin
    logic [TIMER_BITS-1:0] dec;
    driven  = (scan_col < SCAN_NONE);
    found   = 1'b0;
    hit_row = 2'd0;
    for (int r = 0; r < LOCK_ROWS; r++) begin
      dec = (lockout[r] != '0) ? lockout[r] - 1'b1 : lockout[r];
      accept[r] = driven && row_edges[r] && (dec == '0);
      lockout_nxt[r] = accept[r] ? debounce_lim : dec;
      if (accept[r]) begin
        found   = 1'b1;
        hit_row = 2'(r);
      end
    end
  end

  assign hit_ext  = {4'b0000, scan_col};
  assign hit_col  = hit_ext[3:0];
  assign scan_mid = found ? SCAN_NONE : scan_col;

  // advance the scan once the dwell time has run out
  always_comb begin
    dwell_inc = (dwell == TIMER_MAX) ? dwell : dwell + 1'b1;
    if (dwell_inc >= dwell_lim) begin
      scan_col_nxt = (scan_mid >= SCAN_LAST) ? '0 : scan_mid + 1'b1;
      dwell_nxt    = '0;
    end else begin
      scan_col_nxt = scan_mid;
      dwell_nxt    = dwell_inc;
    end
  end

  assign new_ext = {4'b0000, scan_col_nxt};
  assign new_col = new_ext[3:0];

  always_comb begin
    result.column_drive = (scan_col_nxt < SCAN_NONE && new_col < 4'd4) ?
                          (4'b0001 << new_col[1:0]) : 4'b0000;
    result.key_valid    = found;
    result.key_row      = found ? hit_row : 2'd0;
    result.key_column   = found ? hit_col[1:0] : 2'd0;
    result.key_code     = (found && hit_col < 4'd4) ?
                          mks_pkg::key_char(hit_row, hit_col[1:0]) : 8'h00;
  end

endmodule

`default_nettype wire
